[design/lsu_pkg.sv]
`default_nettype none

package lsu_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  localparam int ADDR_BITS_DEF = 16;

  // handled opcodes
  localparam byte_t OP_LDA_IMM  = 8'hA9;
  localparam byte_t OP_LDA_ZP   = 8'hA5;
  localparam byte_t OP_LDA_ZPX  = 8'hB5;
  localparam byte_t OP_LDA_ABS  = 8'hAD;
  localparam byte_t OP_LDA_ABSX = 8'hBD;
  localparam byte_t OP_LDA_ABSY = 8'hB9;
  localparam byte_t OP_LDA_INDX = 8'hA1;
  localparam byte_t OP_LDA_INDY = 8'hB1;
  localparam byte_t OP_LDX_IMM  = 8'hA2;
  localparam byte_t OP_LDX_ZP   = 8'hA6;
  localparam byte_t OP_LDX_ZPY  = 8'hB6;
  localparam byte_t OP_LDX_ABS  = 8'hAE;
  localparam byte_t OP_LDX_ABSY = 8'hBE;
  localparam byte_t OP_LDY_IMM  = 8'hA0;
  localparam byte_t OP_LDY_ZP   = 8'hA4;
  localparam byte_t OP_LDY_ZPX  = 8'hB4;
  localparam byte_t OP_LDY_ABS  = 8'hAC;
  localparam byte_t OP_LDY_ABSX = 8'hBC;
  localparam byte_t OP_STA_ZP   = 8'h85;
  localparam byte_t OP_STA_ZPX  = 8'h95;
  localparam byte_t OP_STA_ABS  = 8'h8D;
  localparam byte_t OP_STA_ABSX = 8'h9D;
  localparam byte_t OP_STA_ABSY = 8'h99;
  localparam byte_t OP_STA_INDX = 8'h81;
  localparam byte_t OP_STA_INDY = 8'h91;
  localparam byte_t OP_STX_ZP   = 8'h86;
  localparam byte_t OP_STX_ZPY  = 8'h96;
  localparam byte_t OP_STX_ABS  = 8'h8E;
  localparam byte_t OP_STY_ZP   = 8'h84;
  localparam byte_t OP_STY_ZPX  = 8'h94;
  localparam byte_t OP_STY_ABS  = 8'h8C;

  typedef enum logic [3:0] {
    M_NONE, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
  } mode_t;

  typedef enum logic [1:0] {R_A, R_X, R_Y} reg_sel_t;

  typedef struct packed {
    mode_t    mode;
    reg_sel_t rsel;
    logic     store;
  } dec_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_EXEC, ST_PTR_HI, ST_PTR_EA, ST_DATA
  } lsu_state_t;

  function automatic dec_t decode_op(input byte_t op);
    dec_t d;
    d = '{M_NONE, R_A, 1'b0};
    case (op)
      OP_LDA_IMM:  d = '{M_IMM,  R_A, 1'b0};
      OP_LDA_ZP:   d = '{M_ZP,   R_A, 1'b0};
      OP_LDA_ZPX:  d = '{M_ZPX,  R_A, 1'b0};
      OP_LDA_ABS:  d = '{M_ABS,  R_A, 1'b0};
      OP_LDA_ABSX: d = '{M_ABSX, R_A, 1'b0};
      OP_LDA_ABSY: d = '{M_ABSY, R_A, 1'b0};
      OP_LDA_INDX: d = '{M_INDX, R_A, 1'b0};
      OP_LDA_INDY: d = '{M_INDY, R_A, 1'b0};
      OP_LDX_IMM:  d = '{M_IMM,  R_X, 1'b0};
      OP_LDX_ZP:   d = '{M_ZP,   R_X, 1'b0};
      OP_LDX_ZPY:  d = '{M_ZPY,  R_X, 1'b0};
      OP_LDX_ABS:  d = '{M_ABS,  R_X, 1'b0};
      OP_LDX_ABSY: d = '{M_ABSY, R_X, 1'b0};
      OP_LDY_IMM:  d = '{M_IMM,  R_Y, 1'b0};
      OP_LDY_ZP:   d = '{M_ZP,   R_Y, 1'b0};
      OP_LDY_ZPX:  d = '{M_ZPX,  R_Y, 1'b0};
      OP_LDY_ABS:  d = '{M_ABS,  R_Y, 1'b0};
      OP_LDY_ABSX: d = '{M_ABSX, R_Y, 1'b0};
      OP_STA_ZP:   d = '{M_ZP,   R_A, 1'b1};
      OP_STA_ZPX:  d = '{M_ZPX,  R_A, 1'b1};
      OP_STA_ABS:  d = '{M_ABS,  R_A, 1'b1};
      OP_STA_ABSX: d = '{M_ABSX, R_A, 1'b1};
      OP_STA_ABSY: d = '{M_ABSY, R_A, 1'b1};
      OP_STA_INDX: d = '{M_INDX, R_A, 1'b1};
      OP_STA_INDY: d = '{M_INDY, R_A, 1'b1};
      OP_STX_ZP:   d = '{M_ZP,   R_X, 1'b1};
      OP_STX_ZPY:  d = '{M_ZPY,  R_X, 1'b1};
      OP_STX_ABS:  d = '{M_ABS,  R_X, 1'b1};
      OP_STY_ZP:   d = '{M_ZP,   R_Y, 1'b1};
      OP_STY_ZPX:  d = '{M_ZPX,  R_Y, 1'b1};
      OP_STY_ABS:  d = '{M_ABS,  R_Y, 1'b1};
      default:     d = '{M_NONE, R_A, 1'b0};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[design/lsu_if.sv]
`default_nettype none

interface lsu_in_if import lsu_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t op;
  word_t operand;

  modport source (output valid, output op, output operand, input ready);
  modport sink (input valid, input op, input operand, output ready);
endinterface

interface lsu_out_if import lsu_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t acc_value;
  byte_t index_x_value;
  byte_t index_y_value;
  logic  zero_flag;
  logic  negative_flag;
  word_t effective_address;
  logic  mem_written;
  logic  unknown_opcode;

  modport source (
    output valid, output acc_value, output index_x_value, output index_y_value,
    output zero_flag, output negative_flag, output effective_address,
    output mem_written, output unknown_opcode, input ready
  );
  modport sink (
    input valid, input acc_value, input index_x_value, input index_y_value,
    input zero_flag, input negative_flag, input effective_address,
    input mem_written, input unknown_opcode, output ready
  );
endinterface

`default_nettype wire

[design/cpu6502_load_store_unit.sv]
// channel  | dir | payload                                              | handshake
// ---------+-----+------------------------------------------------------+------------
// in_ch    | in  | op, operand                                          | valid/ready
// out_ch   | out | acc/x/y values, z/n flags, effective_address,        | valid/ready
//          |     | mem_written, unknown_opcode                          |
//
// memory accesses per item on the single-port data memory (one access a cycle):
//   immediate, unknown opcode: no access; direct store: write; direct load: data read;
//   indirect store: pointer low/high reads, write; indirect load: pointer low, high, data
// after reset a clearing pass writes zero to all 2**ADDR_BITS bytes, one per cycle;
//   in_ch.ready stays low for those cycles
// a result sits in the output register; the next item is taken while it waits,
//   and an item only retires when the output register is free
`default_nettype none

module cpu6502_load_store_unit import lsu_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  lsu_in_if.sink     in_ch,
  lsu_out_if.source  out_ch
);

  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  typedef logic [ADDR_BITS-1:0] maddr_t;

  // sequencer and architectural state
  lsu_state_t state_r, state_nxt;
  maddr_t     clr_cnt_r, clr_cnt_nxt;
  logic       busy_r, busy_nxt;
  byte_t      op_r, op_nxt;
  word_t      operand_r, operand_nxt;
  byte_t      acc_r, acc_nxt;
  byte_t      x_r, x_nxt;
  byte_t      y_r, y_nxt;
  logic       z_r, z_nxt;
  logic       n_r, n_nxt;
  byte_t      ptr_r, ptr_nxt;
  byte_t      ptr_lo_r, ptr_lo_nxt;
  word_t      ea_r, ea_nxt;

  // output register
  logic  out_valid_r, out_valid_nxt;
  byte_t out_acc_r, out_acc_nxt;
  byte_t out_x_r, out_x_nxt;
  byte_t out_y_r, out_y_nxt;
  logic  out_z_r, out_z_nxt;
  logic  out_n_r, out_n_nxt;
  word_t out_ea_r, out_ea_nxt;
  logic  out_wr_r, out_wr_nxt;
  logic  out_unk_r, out_unk_nxt;

  // data memory port
  byte_t  mem [MEM_DEPTH];
  byte_t  rdata_r;
  logic   mem_en;
  logic   mem_we;
  maddr_t mem_addr;
  byte_t  mem_wdata;

  dec_t  dec;
  byte_t lo;
  byte_t ptr0;
  word_t dir_ea;
  word_t ind_ea;
  byte_t st_val;
  logic  out_free;
  logic  finish;
  logic  load_en;
  byte_t load_val;
  word_t res_ea;
  logic  res_wr;
  logic  res_unk;
  logic  in_ready;
  logic  accept;

  always_comb begin
    dec  = decode_op(op_r);
    lo   = operand_r[7:0];
    // (indirect,X) pointer stays in page zero
    ptr0 = (dec.mode == M_INDX) ? byte_t'(lo + x_r) : lo;

    case (dec.mode)
      M_ZP:    dir_ea = {8'h00, lo};
      M_ZPX:   dir_ea = {8'h00, byte_t'(lo + x_r)};
      M_ZPY:   dir_ea = {8'h00, byte_t'(lo + y_r)};
      M_ABS:   dir_ea = operand_r;
      M_ABSX:  dir_ea = word_t'(operand_r + {8'h00, x_r});
      M_ABSY:  dir_ea = word_t'(operand_r + {8'h00, y_r});
      default: dir_ea = '0;
    endcase

    // pointer high byte arrives on the read port in this step
    ind_ea = word_t'({rdata_r, ptr_lo_r} + ((dec.mode == M_INDY) ? {8'h00, y_r} : 16'h0000));

    case (dec.rsel)
      R_A:     st_val = acc_r;
      R_X:     st_val = x_r;
      R_Y:     st_val = y_r;
      default: st_val = acc_r;
    endcase
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // next state, memory port and retire
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    ptr_nxt     = ptr_r;
    ptr_lo_nxt  = ptr_lo_r;
    ea_nxt      = ea_r;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = st_val;
    finish      = 1'b0;
    load_en     = 1'b0;
    load_val    = lo;
    res_ea      = '0;
    res_wr      = 1'b0;
    res_unk     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_en      = 1'b1;
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + maddr_t'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (busy_r) begin
          case (dec.mode)
            M_NONE: begin
              finish  = out_free;
              res_unk = 1'b1;
            end
            M_IMM: begin
              finish   = out_free;
              load_en  = 1'b1;
              load_val = lo;
            end
            M_INDX, M_INDY: begin
              mem_en    = 1'b1;
              mem_addr  = maddr_t'(ptr0);
              ptr_nxt   = ptr0;
              state_nxt = ST_PTR_HI;
            end
            default: begin
              if (dec.store) begin
                if (out_free) begin
                  mem_en   = 1'b1;
                  mem_we   = 1'b1;
                  mem_addr = dir_ea[ADDR_BITS-1:0];
                  finish   = 1'b1;
                  res_ea   = dir_ea;
                  res_wr   = 1'b1;
                end
              end else begin
                mem_en    = 1'b1;
                mem_addr  = dir_ea[ADDR_BITS-1:0];
                ea_nxt    = dir_ea;
                state_nxt = ST_DATA;
              end
            end
          endcase
        end
      end
      ST_PTR_HI: begin
        // high pointer byte wraps within page zero
        mem_en     = 1'b1;
        mem_addr   = maddr_t'(byte_t'(ptr_r + 8'd1));
        ptr_lo_nxt = rdata_r;
        state_nxt  = ST_PTR_EA;
      end
      ST_PTR_EA: begin
        if (dec.store) begin
          if (out_free) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = ind_ea[ADDR_BITS-1:0];
            finish    = 1'b1;
            res_ea    = ind_ea;
            res_wr    = 1'b1;
            state_nxt = ST_EXEC;
          end
        end else begin
          mem_en    = 1'b1;
          mem_addr  = ind_ea[ADDR_BITS-1:0];
          ea_nxt    = ind_ea;
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        // read data holds while the output is stalled, no new read issued
        if (out_free) begin
          finish    = 1'b1;
          load_en   = 1'b1;
          load_val  = rdata_r;
          res_ea    = ea_r;
          state_nxt = ST_EXEC;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // register file update, input capture, output register
  always_comb begin
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    n_nxt   = n_r;
    if (finish && load_en) begin
      case (dec.rsel)
        R_A:     acc_nxt = load_val;
        R_X:     x_nxt   = load_val;
        R_Y:     y_nxt   = load_val;
        default: acc_nxt = load_val;
      endcase
      z_nxt = (load_val == 8'h00);
      n_nxt = load_val[7];
    end

    // a new item may enter in the cycle the current one retires
    in_ready    = (state_r != ST_CLEAR) && (!busy_r || finish);
    accept      = in_ch.valid && in_ready;
    op_nxt      = op_r;
    operand_nxt = operand_r;
    busy_nxt    = busy_r;
    if (accept) begin
      op_nxt      = in_ch.op;
      operand_nxt = in_ch.operand;
      busy_nxt    = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_n_nxt     = out_n_r;
    out_ea_nxt    = out_ea_r;
    out_wr_nxt    = out_wr_r;
    out_unk_nxt   = out_unk_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = acc_nxt;
      out_x_nxt     = x_nxt;
      out_y_nxt     = y_nxt;
      out_z_nxt     = z_nxt;
      out_n_nxt     = n_nxt;
      out_ea_nxt    = res_ea;
      out_wr_nxt    = res_wr;
      out_unk_nxt   = res_unk;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      z_r         <= 1'b0;
      n_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      z_r         <= z_nxt;
      n_r         <= n_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    operand_r <= operand_nxt;
    ptr_r     <= ptr_nxt;
    ptr_lo_r  <= ptr_lo_nxt;
    ea_r      <= ea_nxt;
    out_acc_r <= out_acc_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_z_r   <= out_z_nxt;
    out_n_r   <= out_n_nxt;
    out_ea_r  <= out_ea_nxt;
    out_wr_r  <= out_wr_nxt;
    out_unk_r <= out_unk_nxt;
  end

  // single-port data memory, registered read
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        rdata_r <= mem[mem_addr];
      end
    end
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.acc_value         = out_acc_r;
  assign out_ch.index_x_value     = out_x_r;
  assign out_ch.index_y_value     = out_y_r;
  assign out_ch.zero_flag         = out_z_r;
  assign out_ch.negative_flag     = out_n_r;
  assign out_ch.effective_address = out_ea_r;
  assign out_ch.mem_written       = out_wr_r;
  assign out_ch.unknown_opcode    = out_unk_r;

`ifndef SYNTHESIS
  // no item enters while memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready)
    else $error("item accepted during clearing pass");

  // outside the clearing pass only a retiring store writes memory
  a_write_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR) |-> (finish && dec.store))
    else $error("memory written outside a retiring store");

  // pointer and data steps only run with an item in hand
  a_busy_in_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PTR_HI || state_r == ST_PTR_EA || state_r == ST_DATA) |-> busy_r)
    else $error("sequencer step without an item");

  // a retiring item shows up on the output in the next cycle
  a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_ch.valid)
    else $error("retired item missing on output");
`endif

endmodule

`default_nettype wire

[test/cpu6502_load_store_unit_test.sv]
`default_nettype none

module cpu6502_load_store_unit_test import lsu_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // run length and cycle budget
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int MEM_BYTES   = 1 << ADDR_BITS_DEF;
  localparam int LAST_LOAD   = 17;  // entries 0..17 are loads, 18..30 stores
  localparam int LAST_STORE  = 30;

  // one decoded opcode
  typedef struct packed {
    byte_t    op;
    mode_t    mode;
    reg_sel_t rsel;
    logic     store;
  } opinfo_t;

  // one instruction waiting to be sent; wait_idle holds it back until
  // every earlier instruction has produced its result
  typedef struct {
    byte_t op;
    word_t operand;
    bit    wait_idle;
  } instr_t;

  // architectural state after one instruction, as seen on out_ch
  typedef struct packed {
    byte_t acc_value;
    byte_t index_x_value;
    byte_t index_y_value;
    logic  zero_flag;
    logic  negative_flag;
    word_t effective_address;
    logic  mem_written;
    logic  unknown_opcode;
  } lsu_result_t;

  logic clk;
  logic rst_n;

  lsu_in_if  in_ch ();
  lsu_out_if out_ch ();

  cpu6502_load_store_unit #(
    .ADDR_BITS(ADDR_BITS_DEF)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the cpu state
  byte_t cpu_a;
  byte_t cpu_x;
  byte_t cpu_y;
  logic  cpu_z;
  logic  cpu_n;
  byte_t cpu_mem [0:MEM_BYTES-1];

  instr_t      program_queue[$];
  lsu_result_t predicted_results[$];

  int n_sent = 0;       // items accepted on in_ch
  int n_done = 0;       // items accepted on out_ch
  int n_errors;
  int total_items;
  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // opcode decode
  // --------------------------------------------------------------------------

  function automatic opinfo_t opcode_entry(input int idx);
    case (idx)
      0:  return '{OP_LDA_IMM,  M_IMM,  R_A, 1'b0};
      1:  return '{OP_LDA_ZP,   M_ZP,   R_A, 1'b0};
      2:  return '{OP_LDA_ZPX,  M_ZPX,  R_A, 1'b0};
      3:  return '{OP_LDA_ABS,  M_ABS,  R_A, 1'b0};
      4:  return '{OP_LDA_ABSX, M_ABSX, R_A, 1'b0};
      5:  return '{OP_LDA_ABSY, M_ABSY, R_A, 1'b0};
      6:  return '{OP_LDA_INDX, M_INDX, R_A, 1'b0};
      7:  return '{OP_LDA_INDY, M_INDY, R_A, 1'b0};
      8:  return '{OP_LDX_IMM,  M_IMM,  R_X, 1'b0};
      9:  return '{OP_LDX_ZP,   M_ZP,   R_X, 1'b0};
      10: return '{OP_LDX_ZPY,  M_ZPY,  R_X, 1'b0};
      11: return '{OP_LDX_ABS,  M_ABS,  R_X, 1'b0};
      12: return '{OP_LDX_ABSY, M_ABSY, R_X, 1'b0};
      13: return '{OP_LDY_IMM,  M_IMM,  R_Y, 1'b0};
      14: return '{OP_LDY_ZP,   M_ZP,   R_Y, 1'b0};
      15: return '{OP_LDY_ZPX,  M_ZPX,  R_Y, 1'b0};
      16: return '{OP_LDY_ABS,  M_ABS,  R_Y, 1'b0};
      17: return '{OP_LDY_ABSX, M_ABSX, R_Y, 1'b0};
      18: return '{OP_STA_ZP,   M_ZP,   R_A, 1'b1};
      19: return '{OP_STA_ZPX,  M_ZPX,  R_A, 1'b1};
      20: return '{OP_STA_ABS,  M_ABS,  R_A, 1'b1};
      21: return '{OP_STA_ABSX, M_ABSX, R_A, 1'b1};
      22: return '{OP_STA_ABSY, M_ABSY, R_A, 1'b1};
      23: return '{OP_STA_INDX, M_INDX, R_A, 1'b1};
      24: return '{OP_STA_INDY, M_INDY, R_A, 1'b1};
      25: return '{OP_STX_ZP,   M_ZP,   R_X, 1'b1};
      26: return '{OP_STX_ZPY,  M_ZPY,  R_X, 1'b1};
      27: return '{OP_STX_ABS,  M_ABS,  R_X, 1'b1};
      28: return '{OP_STY_ZP,   M_ZP,   R_Y, 1'b1};
      29: return '{OP_STY_ZPX,  M_ZPX,  R_Y, 1'b1};
      30: return '{OP_STY_ABS,  M_ABS,  R_Y, 1'b1};
      default: return '{8'h00, M_NONE, R_A, 1'b0};
    endcase
  endfunction

  function automatic opinfo_t decode_insn(input byte_t op);
    opinfo_t e;
    for (int i = 0; i <= LAST_STORE; i++) begin
      e = opcode_entry(i);
      if (e.op == op) return e;
    end
    // anything else is not a load or store we handle
    return '{op, M_NONE, R_A, 1'b0};
  endfunction

  // --------------------------------------------------------------------------
  // instruction execution on the shadow state
  // --------------------------------------------------------------------------

  // 16-bit pointer from page zero, high byte wraps within the page
  function automatic word_t zp_pointer(input byte_t p);
    byte_t p_hi;
    p_hi = p + 8'd1;
    return {cpu_mem[p_hi], cpu_mem[p]};
  endfunction

  function automatic lsu_result_t execute_insn(input byte_t op, input word_t operand);
    opinfo_t     info;
    lsu_result_t res;
    byte_t       lo;
    byte_t       value;
    word_t       ea;
    info = decode_insn(op);
    lo   = operand[7:0];
    case (info.mode)
      M_ZP:    ea = {8'h00, lo};
      M_ZPX:   ea = {8'h00, byte_t'(lo + cpu_x)};
      M_ZPY:   ea = {8'h00, byte_t'(lo + cpu_y)};
      M_ABS:   ea = operand;
      M_ABSX:  ea = operand + word_t'(cpu_x);
      M_ABSY:  ea = operand + word_t'(cpu_y);
      M_INDX:  ea = zp_pointer(lo + cpu_x);
      M_INDY:  ea = zp_pointer(lo) + word_t'(cpu_y);
      default: ea = '0;
    endcase

    if (info.mode == M_NONE) begin
      // unknown opcode: nothing changes
    end else if (info.store) begin
      case (info.rsel)
        R_X:     cpu_mem[ea[ADDR_BITS_DEF-1:0]] = cpu_x;
        R_Y:     cpu_mem[ea[ADDR_BITS_DEF-1:0]] = cpu_y;
        default: cpu_mem[ea[ADDR_BITS_DEF-1:0]] = cpu_a;
      endcase
    end else begin
      value = (info.mode == M_IMM) ? lo : cpu_mem[ea[ADDR_BITS_DEF-1:0]];
      case (info.rsel)
        R_X:     cpu_x = value;
        R_Y:     cpu_y = value;
        default: cpu_a = value;
      endcase
      cpu_z = (value == 8'h00);
      cpu_n = value[7];
    end

    res.acc_value         = cpu_a;
    res.index_x_value     = cpu_x;
    res.index_y_value     = cpu_y;
    res.zero_flag         = cpu_z;
    res.negative_flag     = cpu_n;
    res.effective_address = ea;
    res.mem_written       = info.store && (info.mode != M_NONE);
    res.unknown_opcode    = (info.mode == M_NONE);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // program generation
  // --------------------------------------------------------------------------

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // random byte leaning toward the corner values
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'hFF;
      3:       return 8'h7F;
      default: return rand_byte();
    endcase
  endfunction

  // data address, mostly from a small set so that loads find earlier stores
  function automatic word_t pick_addr(input bit zero_page);
    word_t a;
    case ($urandom_range(0, 11))
      0:       a = 16'h0000;
      1:       a = 16'h00FF;
      2:       a = 16'h0100;
      3:       a = 16'h7FFF;
      4:       a = 16'h8000;
      5:       a = 16'hFFFF;
      6:       a = 16'h0010;
      7:       a = 16'h1234;
      default: a = word_t'($urandom_range(0, 65535));
    endcase
    return zero_page ? {8'h00, a[7:0]} : a;
  endfunction

  function automatic bit is_zero_page(input mode_t m);
    return (m == M_ZP) || (m == M_ZPX) || (m == M_ZPY);
  endfunction

  task automatic push_insn(input byte_t op, input word_t operand);
    instr_t it;
    it.op        = op;
    it.operand   = operand;
    // now and then hold the sender until the block has gone quiet
    it.wait_idle = (program_queue.size() % 331 == 0);
    program_queue.push_back(it);
  endtask

  task automatic load_register(input reg_sel_t r, input byte_t v);
    case (r)
      R_X:     push_insn(OP_LDX_IMM, {rand_byte(), v});
      R_Y:     push_insn(OP_LDY_IMM, {rand_byte(), v});
      default: push_insn(OP_LDA_IMM, {rand_byte(), v});
    endcase
  endtask

  // build a pointer at p, p+1 (wrapping in page zero) that holds target
  task automatic setup_pointer(input byte_t p, input word_t target);
    byte_t p_hi;
    p_hi = p + 8'd1;
    load_register(R_A, target[7:0]);
    push_insn(OP_STA_ZP, {rand_byte(), p});
    load_register(R_A, target[15:8]);
    push_insn(OP_STA_ZP, {rand_byte(), p_hi});
  endtask

  // emit whatever index or pointer setup the mode needs so that the access
  // lands on addr, and return the operand for the instruction itself
  task automatic prepare_access(input opinfo_t e, input word_t addr, output word_t operand);
    byte_t k;
    byte_t p;
    k = pick_byte();
    p = ($urandom_range(0, 3) == 0) ? 8'hFF : rand_byte();
    case (e.mode)
      M_ZP:   operand = {rand_byte(), addr[7:0]};
      M_ZPX: begin
        load_register(R_X, k);
        operand = {rand_byte(), byte_t'(addr[7:0] - k)};
      end
      M_ZPY: begin
        load_register(R_Y, k);
        operand = {rand_byte(), byte_t'(addr[7:0] - k)};
      end
      M_ABS:  operand = addr;
      M_ABSX: begin
        load_register(R_X, k);
        operand = addr - word_t'(k);
      end
      M_ABSY: begin
        load_register(R_Y, k);
        operand = addr - word_t'(k);
      end
      M_INDX: begin
        setup_pointer(p, addr);
        load_register(R_X, k);
        operand = {rand_byte(), byte_t'(p - k)};
      end
      M_INDY: begin
        setup_pointer(p, addr - word_t'(k));
        load_register(R_Y, k);
        operand = {rand_byte(), p};
      end
      default: operand = word_t'($urandom_range(0, 65535));
    endcase
  endtask

  // store a value somewhere, then run a random load aimed at the same address
  task automatic store_then_load();
    opinfo_t st;
    opinfo_t ld;
    word_t   addr;
    word_t   st_operand;
    word_t   ld_operand;
    st   = opcode_entry($urandom_range(LAST_LOAD + 1, LAST_STORE));
    ld   = opcode_entry($urandom_range(0, LAST_LOAD));
    addr = pick_addr(is_zero_page(st.mode) || is_zero_page(ld.mode));
    prepare_access(st, addr, st_operand);
    load_register(st.rsel, pick_byte());
    push_insn(st.op, st_operand);
    prepare_access(ld, addr, ld_operand);
    push_insn(ld.op, ld_operand);
  endtask

  task automatic build_directed();
    // immediates: zero, negative, high operand byte ignored
    push_insn(OP_LDA_IMM, 16'h0000);
    push_insn(OP_LDA_IMM, 16'hFF80);
    push_insn(OP_LDX_IMM, 16'h00FF);
    push_insn(OP_LDY_IMM, 16'hAB01);
    // pointer straddling the end of page zero: low byte at $FF, high at $00
    push_insn(OP_STA_ZP, 16'h12FF);
    push_insn(OP_STY_ZP, 16'hFF00);
    push_insn(OP_LDA_INDY, 16'h00FF);
    push_insn(OP_LDA_IMM, 16'h005A);
    push_insn(OP_STA_INDY, 16'hFFFF);
    // (zp,X) where zp + X wraps onto $FF
    push_insn(OP_LDA_INDX, 16'h0000);
    push_insn(OP_STA_INDX, 16'hFF00);
    push_insn(OP_LDA_ABS, 16'h0181);
    // top of memory and 16-bit index wrap
    push_insn(OP_STA_ABS, 16'hFFFF);
    push_insn(OP_LDY_ABSX, 16'hFF00);
    push_insn(OP_LDX_ABSY, 16'hFFFF);
    // zero page indexed wrapping inside page zero
    push_insn(OP_STX_ZPY, 16'h00A6);
    push_insn(OP_LDX_IMM, 16'h0080);
    push_insn(OP_LDA_ZPX, 16'hFF80);
    push_insn(OP_STY_ZPX, 16'h0081);
    push_insn(OP_LDY_ZPX, 16'h0081);
    push_insn(OP_STA_ABSY, 16'hFFFF);
    push_insn(OP_STX_ABS, 16'h8000);
    // unknown opcodes leave everything alone
    push_insn(8'h00, 16'hFFFF);
    push_insn(8'hFF, 16'h0000);
    push_insn(8'hEA, 16'h1234);
  endtask

  task automatic build_random();
    opinfo_t e;
    word_t   operand;
    while (program_queue.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        // single handled instruction with arbitrary operand
        0, 1, 2, 3, 4: begin
          e = opcode_entry($urandom_range(0, LAST_STORE));
          operand = ($urandom_range(0, 1) == 1) ? pick_addr(1'b0)
                                                : word_t'($urandom_range(0, 65535));
          push_insn(e.op, operand);
        end
        // noise: any opcode byte at all
        5, 6, 7:
          push_insn(rand_byte(), word_t'($urandom_range(0, 65535)));
        default:
          store_then_load();
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // idling profile: sender-light/receiver-heavy, then swapped, then none
  // --------------------------------------------------------------------------

  function automatic int idle_pct(input int sent, input bit receiver);
    int phase;
    phase = (total_items == 0) ? 0 : (sent * 3) / total_items;
    case (phase)
      0:       return receiver ? 63 : 37;
      1:       return receiver ? 37 : 63;
      default: return 0;
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // driver: presents items from program_queue, predicts on acceptance
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : drive_items
    logic   fire_in;
    int     in_flight;
    instr_t nxt;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.op      <= '0;
      in_ch.operand <= '0;
    end else begin
      fire_in = in_ch.valid && in_ch.ready;
      if (fire_in) begin
        predicted_results.push_back(execute_insn(in_ch.op, in_ch.operand));
        n_sent <= n_sent + 1;
      end
      // a presented item stays put until taken
      if (!in_ch.valid || fire_in) begin
        // results still owed once this edge's handshakes are counted
        in_flight = n_sent + int'(fire_in) - n_done - int'(out_ch.valid && out_ch.ready);
        if (program_queue.size() != 0
            && !(program_queue[0].wait_idle && in_flight != 0)
            && $urandom_range(0, 99) >= idle_pct(n_sent, 1'b0)) begin
          nxt = program_queue.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.op      <= nxt.op;
          in_ch.operand <= nxt.operand;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: compares each result with the oldest prediction
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    lsu_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_done <= n_done + 1;
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing predicted, expected none, actual ea %0h",
                   $time, out_ch.effective_address);
          n_errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("acc_value", want.acc_value, out_ch.acc_value);
          check_field("index_x_value", want.index_x_value, out_ch.index_x_value);
          check_field("index_y_value", want.index_y_value, out_ch.index_y_value);
          check_field("zero_flag", want.zero_flag, out_ch.zero_flag);
          check_field("negative_flag", want.negative_flag, out_ch.negative_flag);
          check_field("effective_address", want.effective_address,
                      out_ch.effective_address);
          check_field("mem_written", want.mem_written, out_ch.mem_written);
          check_field("unknown_opcode", want.unknown_opcode, out_ch.unknown_opcode);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(n_sent, 1'b1));
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: covers the memory clearing pass plus a slow run many times over
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin : run
    rst_n       = 1'b0;
    n_errors    = 0;
    // shadow state matches the block after reset, memory included
    cpu_a = '0;
    cpu_x = '0;
    cpu_y = '0;
    cpu_z = 1'b0;
    cpu_n = 1'b0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;

    build_directed();
    build_random();
    total_items = program_queue.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // all items sent and every result back
    do @(negedge clk);
    while (program_queue.size() != 0 || in_ch.valid || n_sent != n_done);
    // catch any stray result after the last one
    repeat (TAIL_CYCLES) @(negedge clk);

    if (predicted_results.size() != 0) begin
      $display("%0t: %0d results missing, expected 0 outstanding, actual %0d",
               $time, predicted_results.size(), predicted_results.size());
      n_errors++;
    end

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/lsu_pkg.sv
design/lsu_if.sv
design/cpu6502_load_store_unit.sv
test/cpu6502_load_store_unit_test.sv
